>>> rtl/core/htsd_pkg.sv
// ----------------------------------------------------------------------------
// htsd_pkg
// Shared constants and the node entry layout for the Huffman stream decoder.
// ----------------------------------------------------------------------------
package htsd_pkg;

  localparam int NODE_DEPTH = 512;
  localparam int ADDR_W     = $clog2(NODE_DEPTH);
  localparam int CNT_W      = $clog2(NODE_DEPTH + 1);
  localparam int SYM_W      = 8;
  localparam int BCNT_W     = 4;
  localparam int WORD_BITS  = 8;

  typedef logic [ADDR_W-1:0] node_idx_t;

  typedef struct packed {
    logic              is_leaf;
    logic [SYM_W-1:0]  value;
    node_idx_t         left;
    logic              left_ok;
    node_idx_t         right;
    logic              right_ok;
    node_idx_t         parent;
    logic              parent_ok;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

>>> rtl/core/htsd_ram.sv
// ----------------------------------------------------------------------------
// htsd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/huffman_tree_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_top
// Rebuilds a Huffman tree from a preorder bit stream, then decodes symbols.
// ----------------------------------------------------------------------------
// Sequence: a word is taken in idle, then each valid bit in turn: a leaf flag, value
//   bit, root node or ignored bit directly; a node that attaches reads its parent,
//   then updates it and climbs through each full ancestor; a decode bit reads, looks up
//   and tests for a leaf. Results and the finish add steps; out stalls hold it. One word at a time.
// Reset: control state cleared; the node RAM is not cleared (read only after
//   write), so no clearing pass follows reset.
module huffman_tree_stream_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_code_byte,
  input  logic [htsd_pkg::BCNT_W-1:0] in_bit_count,
  input  logic                       in_new_stream,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [htsd_pkg::SYM_W-1:0] out_decoded_byte,
  output logic                       out_error,
  output logic                       out_last
);
  import htsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIT, ST_UPD, ST_CLIMB, ST_LOOK, ST_LEAF, ST_EMIT, ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {PH_NODE, PH_VALUE, PH_DATA, PH_HALT} phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         sh_r, sh_nxt;
  logic [BCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   node_count_r, node_count_nxt;
  node_idx_t          build_cursor_r, build_cursor_nxt;
  logic               bcv_r, bcv_nxt;
  logic               tree_started_r, tree_started_nxt;
  node_idx_t          lookup_r, lookup_nxt;
  logic [SYM_W-1:0]   leaf_shift_r, leaf_shift_nxt;
  logic [BCNT_W-1:0]  leaf_left_r, leaf_left_nxt;
  node_idx_t          child_r, child_nxt;
  logic               descend_r, descend_nxt;
  logic [SYM_W-1:0]   ev_byte_r, ev_byte_nxt;
  logic               ev_err_r, ev_err_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]   pend_byte_r, pend_byte_nxt;
  logic               pend_err_r, pend_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_byte_r, out_byte_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_last_r, out_last_nxt;

  logic               wr_en, rd_en;
  node_idx_t          wr_addr, rd_addr;
  node_t              wr_node, new_node, upd_node, rd_node;
  logic [NODE_W-1:0]  rd_data;

  logic               advance, bit_cur, full, out_free;
  logic [BCNT_W-1:0]  cnt_sat, leaf_left_v;
  logic [SYM_W-1:0]   shift_v;
  node_idx_t          node_idx;

  htsd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_node  = node_t'(rd_data);
  assign bit_cur  = sh_r[7];
  assign full     = (node_count_r == CNT_W'(NODE_DEPTH));
  assign node_idx = node_count_r[ADDR_W-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_sat  = (in_bit_count > BCNT_W'(WORD_BITS)) ? BCNT_W'(WORD_BITS) : in_bit_count;
  assign shift_v  = {leaf_shift_r[SYM_W-2:0], bit_cur};
  assign leaf_left_v = leaf_left_r - BCNT_W'(leaf_left_r != '0);

  always_comb begin
    new_node           = '0;
    new_node.parent    = build_cursor_r;
    new_node.parent_ok = tree_started_r && bcv_r;
    upd_node           = rd_node;
    if (!rd_node.left_ok) begin
      upd_node.left    = child_r;
      upd_node.left_ok = 1'b1;
    end else begin
      upd_node.right    = child_r;
      upd_node.right_ok = 1'b1;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    sh_nxt           = sh_r;
    cnt_nxt          = cnt_r;
    node_count_nxt   = node_count_r;
    build_cursor_nxt = build_cursor_r;
    bcv_nxt          = bcv_r;
    tree_started_nxt = tree_started_r;
    lookup_nxt       = lookup_r;
    leaf_shift_nxt   = leaf_shift_r;
    leaf_left_nxt    = leaf_left_r;
    child_nxt        = child_r;
    descend_nxt      = descend_r;
    ev_byte_nxt      = ev_byte_r;
    ev_err_nxt       = ev_err_r;
    pend_valid_nxt   = pend_valid_r;
    pend_byte_nxt    = pend_byte_r;
    pend_err_nxt     = pend_err_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_byte_nxt     = out_byte_r;
    out_err_nxt      = out_err_r;
    out_last_nxt     = out_last_r;
    wr_en            = 1'b0;
    wr_addr          = node_idx;
    wr_node          = new_node;
    rd_en            = 1'b0;
    rd_addr          = build_cursor_r;
    advance          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = cnt_sat;
          sh_nxt    = in_code_byte << (BCNT_W'(WORD_BITS) - cnt_sat);
          state_nxt = (cnt_sat == '0) ? ST_IDLE : ST_BIT;
          if (in_new_stream) begin
            node_count_nxt   = '0;
            phase_nxt        = PH_NODE;
            build_cursor_nxt = '0;
            bcv_nxt          = 1'b0;
            tree_started_nxt = 1'b0;
            lookup_nxt       = '0;
            leaf_shift_nxt   = '0;
            leaf_left_nxt    = '0;
          end
        end
      end
      ST_BIT: begin
        unique case (phase_r)
          PH_HALT: advance = 1'b1;
          PH_NODE: begin
            if (bit_cur) begin
              phase_nxt      = PH_VALUE;
              leaf_left_nxt  = BCNT_W'(WORD_BITS);
              leaf_shift_nxt = '0;
              advance        = 1'b1;
            end else if (full) begin
              phase_nxt   = PH_HALT;
              ev_byte_nxt = '0;
              ev_err_nxt  = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              wr_en          = 1'b1;
              node_count_nxt = node_count_r + CNT_W'(1);
              if (!tree_started_r || !bcv_r) begin
                tree_started_nxt = 1'b1;
                bcv_nxt          = 1'b1;
                build_cursor_nxt = node_idx;
                lookup_nxt       = node_idx;
                advance          = 1'b1;
              end else begin
                child_nxt   = node_idx;
                descend_nxt = 1'b1;
                rd_en       = 1'b1;
                state_nxt   = ST_UPD;
              end
            end
          end
          PH_VALUE: begin
            leaf_shift_nxt = shift_v;
            leaf_left_nxt  = leaf_left_v;
            if (leaf_left_v != '0) begin
              advance = 1'b1;
            end else if (!bcv_r || full) begin
              phase_nxt   = PH_HALT;
              ev_byte_nxt = '0;
              ev_err_nxt  = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              wr_en          = 1'b1;
              wr_node.is_leaf = 1'b1;
              wr_node.value  = shift_v;
              node_count_nxt = node_count_r + CNT_W'(1);
              phase_nxt      = PH_NODE;
              child_nxt      = node_idx;
              descend_nxt    = 1'b0;
              rd_en          = 1'b1;
              state_nxt      = ST_UPD;
            end
          end
          PH_DATA: begin
            rd_en     = 1'b1;
            rd_addr   = lookup_r;
            state_nxt = ST_LOOK;
          end
          default: advance = 1'b1;
        endcase
      end
      ST_UPD: begin
        wr_en   = 1'b1;
        wr_addr = build_cursor_r;
        wr_node = upd_node;
        if (descend_r) begin
          build_cursor_nxt = child_r;
          advance          = 1'b1;
        end else if (!rd_node.left_ok) begin
          advance = 1'b1;
        end else if (!rd_node.parent_ok) begin
          phase_nxt  = PH_DATA;
          bcv_nxt    = 1'b0;
          lookup_nxt = '0;
          advance    = 1'b1;
        end else begin
          build_cursor_nxt = rd_node.parent;
          rd_en            = 1'b1;
          rd_addr          = rd_node.parent;
          state_nxt        = ST_CLIMB;
        end
      end
      ST_CLIMB: begin
        if (!rd_node.left_ok || !rd_node.right_ok) begin
          advance = 1'b1;
        end else if (!rd_node.parent_ok) begin
          phase_nxt  = PH_DATA;
          bcv_nxt    = 1'b0;
          lookup_nxt = '0;
          advance    = 1'b1;
        end else begin
          build_cursor_nxt = rd_node.parent;
          rd_en            = 1'b1;
          rd_addr          = rd_node.parent;
        end
      end
      ST_LOOK: begin
        if (bit_cur ? !rd_node.left_ok : !rd_node.right_ok) begin
          phase_nxt   = PH_HALT;
          ev_byte_nxt = '0;
          ev_err_nxt  = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          child_nxt = bit_cur ? rd_node.left : rd_node.right;
          rd_en     = 1'b1;
          rd_addr   = bit_cur ? rd_node.left : rd_node.right;
          state_nxt = ST_LEAF;
        end
      end
      ST_LEAF: begin
        if (rd_node.is_leaf) begin
          lookup_nxt  = '0;
          ev_byte_nxt = rd_node.value;
          ev_err_nxt  = 1'b0;
          state_nxt   = ST_EMIT;
        end else begin
          lookup_nxt = child_r;
          advance    = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!pend_valid_r) begin
          pend_valid_nxt = 1'b1;
          pend_byte_nxt  = ev_byte_r;
          pend_err_nxt   = ev_err_r;
          advance        = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_byte_r;
          out_err_nxt   = pend_err_r;
          out_last_nxt  = 1'b0;
          pend_byte_nxt = ev_byte_r;
          pend_err_nxt  = ev_err_r;
          advance       = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = pend_byte_r;
          out_err_nxt    = pend_err_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (advance) begin
      sh_nxt    = sh_r << 1;
      cnt_nxt   = cnt_r - BCNT_W'(1);
      state_nxt = (cnt_r == BCNT_W'(1)) ? ST_FLUSH : ST_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      phase_r        <= PH_NODE;
      node_count_r   <= '0;
      build_cursor_r <= '0;
      bcv_r          <= 1'b0;
      tree_started_r <= 1'b0;
      lookup_r       <= '0;
      leaf_shift_r   <= '0;
      leaf_left_r    <= '0;
      cnt_r          <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      node_count_r   <= node_count_nxt;
      build_cursor_r <= build_cursor_nxt;
      bcv_r          <= bcv_nxt;
      tree_started_r <= tree_started_nxt;
      lookup_r       <= lookup_nxt;
      leaf_shift_r   <= leaf_shift_nxt;
      leaf_left_r    <= leaf_left_nxt;
      cnt_r          <= cnt_nxt;
      pend_valid_r   <= pend_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    sh_r        <= sh_nxt;
    child_r     <= child_nxt;
    descend_r   <= descend_nxt;
    ev_byte_r   <= ev_byte_nxt;
    ev_err_r    <= ev_err_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_err_r  <= pend_err_nxt;
    out_byte_r  <= out_byte_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_decoded_byte = out_byte_r;
  assign out_error        = out_err_r;
  assign out_last         = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= CNT_W'(NODE_DEPTH))
    else $error("node count above depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_byte_r == '0)
    else $error("error word carries a symbol");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && pend_err_r |-> phase_r == PH_HALT)
    else $error("error pending without halt");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !pend_valid_r)
    else $error("word taken with a result still pending");

  a_decode_tree: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> tree_started_r && !bcv_r)
    else $error("decoding without a finished tree");

endmodule
